FILE: hdl/dspe_pkg.sv
// ----------------------------------------------------------------------------
// Disc sector payload extractor package
// Shared constants, status codes and the sector size table.
// ----------------------------------------------------------------------------
package dspe_pkg;

    localparam int unsigned MAX_SECTOR_BYTES = 2448;
    localparam int unsigned POS_W            = 12;
    localparam int unsigned START_W          = 5;
    localparam int unsigned PAYLOAD_BYTES    = 2048;

    localparam logic [POS_W-1:0]   MODE_BYTE_POS  = POS_W'(15);
    localparam logic [START_W-1:0] START_MODE1    = START_W'(16);
    localparam logic [START_W-1:0] START_MODE2    = START_W'(24);
    localparam logic [START_W-1:0] START_2336     = START_W'(8);
    localparam logic [START_W-1:0] START_NONE     = START_W'(0);
    localparam logic [7:0]         MODE1          = 8'd1;
    localparam logic [7:0]         MODE2          = 8'd2;

    typedef enum logic [1:0]
    {
        FMT_2048 = 2'd0,
        FMT_2336 = 2'd1,
        FMT_2352 = 2'd2,
        FMT_2448 = 2'd3
    } sector_format_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_BAD_MODE = 2'd1,
        STATUS_AUDIO    = 2'd2
    } status_t;

    localparam logic CFG_SECTOR_FORMAT = 1'b0;
    localparam logic CFG_TRACK_IS_DATA = 1'b1;

    function automatic logic [POS_W-1:0] raw_size_of(input sector_format_t fmt);
        logic [POS_W-1:0] size;
        begin
            unique case (fmt)
                FMT_2048: size = POS_W'(2048);
                FMT_2336: size = POS_W'(2336);
                FMT_2352: size = POS_W'(2352);
                FMT_2448: size = POS_W'(2448);
                default:  size = POS_W'(2048);
            endcase
            if (size > POS_W'(MAX_SECTOR_BYTES))
            begin
                size = POS_W'(MAX_SECTOR_BYTES);
            end
            return size;
        end
    endfunction

endpackage

FILE: hdl/disc_sector_payload_extract.sv
// ----------------------------------------------------------------------------
// Disc sector payload extractor
// Passes the 2048 user-data bytes of each raw disc sector and flags errors.
// ----------------------------------------------------------------------------
// The block takes one raw byte a cycle while in_stall is low and gives at most
// one result word per input word, in the cycle after it, from a single result
// register; an input word is taken in every cycle in which the result register
// is empty or being emptied, so the sustained rate is one byte per clock while
// out_stall is low. The sector position counter, the payload start found from
// the mode byte and the drop flag are updated in the same cycle as the byte is
// taken. Configuration writes are always ready and take effect at once.
module disc_sector_payload_extract
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       last_in_sector,
    output logic [1:0] status
);

    localparam int unsigned POS_W   = dspe_pkg::POS_W;
    localparam int unsigned START_W = dspe_pkg::START_W;

    dspe_pkg::sector_format_t fmt_reg;
    logic                     data_track_reg;

    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [START_W-1:0] start_reg, start_next;
    logic               drop_reg,  drop_next;

    logic               out_valid_reg;
    logic [7:0]         payload_reg;
    logic               last_reg;
    dspe_pkg::status_t  status_reg;

    logic               accept;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               emit_last;
    dspe_pkg::status_t  emit_status;

    logic [POS_W-1:0]   size;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic               known;
    logic [POS_W:0]     pos_inc;
    logic               sector_begin;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        size         = dspe_pkg::raw_size_of(fmt_reg);
        sector_begin = (pos_reg == '0);
        start_next   = sector_begin ? dspe_pkg::START_NONE : start_reg;
        drop_next    = sector_begin ? 1'b0 : drop_reg;
        emit         = 1'b0;
        emit_byte    = 8'd0;
        emit_last    = 1'b0;
        emit_status  = dspe_pkg::STATUS_OK;
        known        = 1'b1;
        start_pos    = '0;
        end_pos      = POS_W'(dspe_pkg::PAYLOAD_BYTES - 1);

        if (!data_track_reg)
        begin
            if (sector_begin)
            begin
                emit        = 1'b1;
                emit_last   = 1'b1;
                emit_status = dspe_pkg::STATUS_AUDIO;
            end
        end
        else if (!drop_next)
        begin
            if ((fmt_reg == dspe_pkg::FMT_2352 || fmt_reg == dspe_pkg::FMT_2448)
                && pos_reg == dspe_pkg::MODE_BYTE_POS)
            begin
                if (raw_byte == dspe_pkg::MODE1)
                begin
                    start_next = dspe_pkg::START_MODE1;
                end
                else if (raw_byte == dspe_pkg::MODE2)
                begin
                    start_next = dspe_pkg::START_MODE2;
                end
                else
                begin
                    drop_next   = 1'b1;
                    emit        = 1'b1;
                    emit_last   = 1'b1;
                    emit_status = dspe_pkg::STATUS_BAD_MODE;
                end
            end
            if (!emit)
            begin
                unique case (fmt_reg)
                    dspe_pkg::FMT_2048: start_pos = '0;
                    dspe_pkg::FMT_2336: start_pos = POS_W'(dspe_pkg::START_2336);
                    default:
                    begin
                        start_pos = POS_W'(start_next);
                        known     = (start_next != dspe_pkg::START_NONE);
                    end
                endcase
                end_pos = start_pos + POS_W'(dspe_pkg::PAYLOAD_BYTES - 1);
                if (known && pos_reg >= start_pos && pos_reg <= end_pos
                    && pos_reg < size)
                begin
                    emit      = 1'b1;
                    emit_byte = raw_byte;
                    emit_last = (pos_reg == end_pos);
                end
            end
        end

        pos_inc  = {1'b0, pos_reg} + (POS_W+1)'(1);
        pos_next = (pos_inc >= {1'b0, size}) ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= dspe_pkg::FMT_2048;
            data_track_reg <= 1'b1;
            pos_reg        <= '0;
            start_reg      <= '0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == dspe_pkg::CFG_SECTOR_FORMAT)
                begin
                    fmt_reg <= dspe_pkg::sector_format_t'(cfg_data);
                end
                else
                begin
                    data_track_reg <= cfg_data[0];
                end
            end
            if (accept)
            begin
                pos_reg   <= pos_next;
                start_reg <= start_next;
                drop_reg  <= drop_next;
            end
            if (accept)
            begin
                out_valid_reg <= emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            payload_reg <= emit_byte;
            last_reg    <= emit_last;
            status_reg  <= emit_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = payload_reg;
    assign last_in_sector = last_reg;
    assign status         = status_reg;

endmodule

FILE: tb/sv/disc_sector_payload_extract_tb.sv
// ----------------------------------------------------------------------------
// Disc sector payload extractor testbench
// Streams raw sector bytes through the extractor under every sector format
// and track type, predicts each result word with an in-bench sector tracker
// and checks the words that come out, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module disc_sector_payload_extract_tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;

    typedef struct packed
    {
        logic [7:0]        data;
        logic              last;
        dspe_pkg::status_t st;
    } sector_word_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic       cfg_index      = dspe_pkg::CFG_SECTOR_FORMAT;
    logic [1:0] cfg_data       = 2'd0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] raw_byte       = 8'd0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] payload_byte;
    logic       last_in_sector;
    logic [1:0] status;

    logic [7:0]   raw_stream[$];
    sector_word_t expected_words[$];
    sector_word_t next_word;
    sector_word_t due_word;
    bit           byte_taken;

    dspe_pkg::sector_format_t cur_format     = dspe_pkg::FMT_2048;
    logic                     cur_track_data = 1'b1;
    logic [11:0]              sector_pos     = '0;
    logic [4:0]               mode_start     = dspe_pkg::START_NONE;
    logic                     dropping       = 1'b0;

    bit steady_flow = 1'b0;
    int send_wait   = 0;
    int recv_wait   = 0;
    int idle_cycles = 0;
    int error_count = 0;

    disc_sector_payload_extract u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_byte       (raw_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .last_in_sector (last_in_sector),
        .status         (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned raw_sector_bytes(input dspe_pkg::sector_format_t fmt);
        int unsigned n;
        case (fmt)
            dspe_pkg::FMT_2048: n = 2048;
            dspe_pkg::FMT_2336: n = 2336;
            dspe_pkg::FMT_2352: n = 2352;
            default:            n = 2448;
        endcase
        if (n > dspe_pkg::MAX_SECTOR_BYTES)
        begin
            n = dspe_pkg::MAX_SECTOR_BYTES;
        end
        return n;
    endfunction

    function automatic int unsigned bytes_left();
        int unsigned size;
        size = raw_sector_bytes(cur_format);
        return (sector_pos >= size) ? 1 : size - sector_pos;
    endfunction

    // Advances the sector tracker by one raw byte and reports whether a word results.
    function automatic bit extract_step(input logic [7:0] b, output sector_word_t w);
        int unsigned size;
        int unsigned p;
        int unsigned first;
        bit          known;
        bit          hit;
        size  = raw_sector_bytes(cur_format);
        p     = sector_pos;
        first = 0;
        known = 1'b1;
        hit   = 1'b0;
        w     = '0;
        if (p == 0)
        begin
            mode_start = dspe_pkg::START_NONE;
            dropping   = 1'b0;
        end
        if (!cur_track_data)
        begin
            if (p == 0)
            begin
                w.last = 1'b1;
                w.st   = dspe_pkg::STATUS_AUDIO;
                hit    = 1'b1;
            end
        end
        else if (!dropping)
        begin
            if ((cur_format == dspe_pkg::FMT_2352 || cur_format == dspe_pkg::FMT_2448)
                && p == dspe_pkg::MODE_BYTE_POS)
            begin
                if (b == dspe_pkg::MODE1)
                begin
                    mode_start = dspe_pkg::START_MODE1;
                end
                else if (b == dspe_pkg::MODE2)
                begin
                    mode_start = dspe_pkg::START_MODE2;
                end
                else
                begin
                    dropping = 1'b1;
                    w.last   = 1'b1;
                    w.st     = dspe_pkg::STATUS_BAD_MODE;
                    hit      = 1'b1;
                end
            end
            if (!hit)
            begin
                case (cur_format)
                    dspe_pkg::FMT_2048: first = 0;
                    dspe_pkg::FMT_2336: first = dspe_pkg::START_2336;
                    default:
                    begin
                        first = mode_start;
                        known = (mode_start != dspe_pkg::START_NONE);
                    end
                endcase
                if (known && p >= first && p < first + dspe_pkg::PAYLOAD_BYTES && p < size)
                begin
                    w.data = b;
                    w.last = (p == first + dspe_pkg::PAYLOAD_BYTES - 1);
                    w.st   = dspe_pkg::STATUS_OK;
                    hit    = 1'b1;
                end
            end
        end
        p = p + 1;
        if (p >= size)
        begin
            p = 0;
        end
        sector_pos = 12'(p);
        return hit;
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    task automatic configure(input dspe_pkg::sector_format_t fmt, input logic track_data);
        cfg_valid <= 1'b1;
        cfg_index <= dspe_pkg::CFG_SECTOR_FORMAT;
        cfg_data  <= fmt;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_format = fmt;
        cfg_index <= dspe_pkg::CFG_TRACK_IS_DATA;
        cfg_data  <= {1'b0, track_data};
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_track_data = track_data;
        cfg_valid <= 1'b0;
    endtask

    // Builds a sector-aligned byte stream, placing a mode byte where raw formats expect one.
    task automatic queue_stream(input int count, input int good_mode_pct);
        int unsigned size;
        int unsigned p;
        logic [7:0]  b;
        size = raw_sector_bytes(cur_format);
        p    = sector_pos;
        repeat (count)
        begin
            b = 8'($urandom_range(0, 255));
            if (p == dspe_pkg::MODE_BYTE_POS
                && (cur_format == dspe_pkg::FMT_2352 || cur_format == dspe_pkg::FMT_2448))
            begin
                if ($urandom_range(1, 100) <= good_mode_pct)
                begin
                    b = $urandom_range(0, 1) ? dspe_pkg::MODE1 : dspe_pkg::MODE2;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    b = 8'h00;
                end
                else
                begin
                    b = 8'($urandom_range(3, 255));
                end
            end
            raw_stream = {raw_stream, b};
            p = (p + 1 >= size) ? 0 : p + 1;
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (raw_stream.size() != 0 || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input dspe_pkg::sector_format_t fmt, input logic track_data,
                             input int sectors, input int extra, input int good_pct);
        int count;
        steady_flow = ($urandom_range(0, 3) == 0);
        configure(fmt, track_data);
        count = extra;
        if (sectors > 0)
        begin
            count += bytes_left() + (sectors - 1) * raw_sector_bytes(fmt);
        end
        queue_stream(count, good_pct);
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            raw_byte <= 8'd0;
            send_wait = 0;
        end
        else
        begin
            byte_taken = in_valid && !in_stall;
            if (byte_taken)
            begin
                if (extract_step(raw_byte, next_word))
                begin
                    expected_words = {expected_words, next_word};
                end
                void'(raw_stream.pop_front());
                send_wait = steady_flow ? 0 : $urandom_range(0, 3);
            end
            if (!in_valid || byte_taken)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait--;
                end
                else if (raw_stream.size() != 0)
                begin
                    in_valid <= 1'b1;
                    raw_byte <= raw_stream[0];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    note_failure($sformatf("unexpected word: data %h last %b status %0d",
                                           payload_byte, last_in_sector, status));
                end
                else
                begin
                    due_word = expected_words.pop_front();
                    if (payload_byte !== due_word.data || last_in_sector !== due_word.last ||
                        status !== due_word.st)
                    begin
                        note_failure($sformatf(
                            "word mismatch: expected data %h last %b status %0d, got %h %b %0d",
                            due_word.data, due_word.last, due_word.st,
                            payload_byte, last_in_sector, status));
                    end
                end
                recv_wait = steady_flow ? 0 : $urandom_range(0, 3);
            end
            if (recv_wait > 0)
            begin
                out_stall <= 1'b1;
                recv_wait--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** disc_sector_payload_extract: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // A few bytes at the reset settings, with the extreme values.
        raw_stream = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h02};
        wait_drained();

        // The first sector meets a good mode byte and changes format part way through.
        run_phase(dspe_pkg::FMT_2352, 1'b1, 0, 50, 100);
        run_phase(dspe_pkg::FMT_2336, 1'b1, 0, 60, 100);
        run_phase(dspe_pkg::FMT_2448, 1'b1, 0, 60, 100);
        run_phase(dspe_pkg::FMT_2352, 1'b0, 0, 60, 100);
        run_phase(dspe_pkg::FMT_2048, 1'b1, 1, 0, 100);

        // The second sector opens on an audio track and then meets a bad mode byte.
        run_phase(dspe_pkg::FMT_2448, 1'b0, 0, 4, 100);
        run_phase(dspe_pkg::FMT_2352, 1'b1, 0, 30, 0);

        wait_drained();
        if (error_count == 0)
        begin
            $display("** disc_sector_payload_extract: PASSED **");
        end
        else
        begin
            $display("** disc_sector_payload_extract: FAILED **");
        end
        $finish;
    end

endmodule

FILE: disc_sector_payload_extract.f
hdl/dspe_pkg.sv
hdl/disc_sector_payload_extract.sv
tb/sv/disc_sector_payload_extract_tb.sv
